@@ src/tfn_pkg.sv @@
// constants, types and payload structs for the triangle face normal pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

	// input coordinate width, signed Q16.16
	localparam int COORD_WIDTH = 32;

	// front end widths
	localparam int EDGE_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = CROSS_W;
	localparam int BL_W    = $clog2(MAG_W + 1);

	// normalized magnitudes, squares and root
	localparam int M_W    = 31;
	localparam int SQ_W   = 2 * M_W;
	localparam int SUM_W  = 64;
	localparam int ROOT_W = 32;

	// division and output
	localparam int FRAC_W = 30;
	localparam int NUM_W  = M_W + FRAC_W + 1;
	localparam int QUO_W  = 31;
	localparam int OUT_W  = 32;

	// stage counts
	localparam int FRONT_STG = 7;
	localparam int SQ_STG    = ROOT_W;
	localparam int DV_STG    = QUO_W;
	localparam int NST       = FRONT_STG + SQ_STG + DV_STG + 1;

	localparam logic [QUO_W-1:0] ONE_Q30 = QUO_W'(1) << FRAC_W;

	typedef logic [M_W-1:0] mnorm_t;

	// payload carried alongside the square root
	typedef struct packed {
		mnorm_t [2:0] m;
		logic [2:0]   neg;
		logic         dg;
	} sq_side_t;

	// payload carried alongside the division
	typedef struct packed {
		logic [2:0] neg;
		logic       dg;
	} dv_side_t;

endpackage
`default_nettype wire

@@ src/tfn_sqrt.sv @@
// pipelined integer square root, one root bit per stage
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none
module tfn_sqrt import tfn_pkg::*; (
	input  wire logic              clk,
	input  wire logic [SQ_STG-1:0] en,
	input  wire logic [SUM_W-1:0]  sum,
	input  wire sq_side_t          side_in,
	output logic [ROOT_W-1:0]      root,
	output sq_side_t               side_out
);

	localparam int TW = SUM_W + 2;

	logic [SUM_W-1:0]  rem_s  [SQ_STG];
	logic [ROOT_W-1:0] root_s [SQ_STG];
	sq_side_t          side_s [SQ_STG];

	for (genvar k = 0; k < SQ_STG; k++) begin : g_stg
		localparam int B = SQ_STG - 1 - k;
		logic [SUM_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		sq_side_t          side_i;
		logic [TW-1:0]     trial;
		logic [SUM_W-1:0]  rem_n;
		logic [ROOT_W-1:0] root_n;

		// stage input
		if (k == 0) begin : g_first
			assign rem_i  = sum;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		// try setting this root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
		always_comb begin
			trial  = (TW'(root_i) << (B + 1)) | (TW'(1) << (2 * B));
			rem_n  = rem_i;
			root_n = root_i;
			if (TW'(rem_i) >= trial) begin
				rem_n  = rem_i - trial[SUM_W-1:0];
				root_n = root_i | (ROOT_W'(1) << B);
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= rem_n;
				root_s[k] <= root_n;
				side_s[k] <= side_i;
			end
		end
	end

	assign root     = root_s[SQ_STG-1];
	assign side_out = side_s[SQ_STG-1];

endmodule
`default_nettype wire

@@ src/tfn_div.sv @@
// pipelined restoring divider, three lanes sharing one divisor,
// one quotient bit per stage; depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none
module tfn_div import tfn_pkg::*; (
	input  wire logic              clk,
	input  wire logic [DV_STG-1:0] en,
	input  wire logic [ROOT_W-1:0] len,
	input  wire sq_side_t          side_in,
	output logic [QUO_W-1:0]       quo [3],
	output dv_side_t               side_out
);

	logic [ROOT_W-1:0] rem_s  [DV_STG][3];
	logic [QUO_W-1:0]  nlo_s  [DV_STG][3];
	logic [QUO_W-1:0]  q_s    [DV_STG][3];
	logic [ROOT_W-1:0] len_s  [DV_STG];
	dv_side_t          side_s [DV_STG];

	// numerator m * 2^30 + len/2, split into the part above the quotient bits
	logic [NUM_W-1:0]  num  [3];
	logic [ROOT_W-1:0] rem0 [3];
	logic [QUO_W-1:0]  nlo0 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i]  = (NUM_W'(side_in.m[i]) << FRAC_W) + NUM_W'(len >> 1);
			rem0[i] = ROOT_W'(num[i] >> QUO_W);
			nlo0[i] = num[i][QUO_W-1:0];
		end
	end

	for (genvar k = 0; k < DV_STG; k++) begin : g_stg
		localparam int J = DV_STG - 1 - k;
		logic [ROOT_W-1:0] rem_i [3];
		logic [QUO_W-1:0]  nlo_i [3];
		logic [QUO_W-1:0]  q_i   [3];
		logic [ROOT_W-1:0] len_i;
		dv_side_t          side_i;
		logic [ROOT_W:0]   r     [3];
		logic [ROOT_W-1:0] rem_n [3];
		logic [QUO_W-1:0]  q_n   [3];

		if (k == 0) begin : g_first
			assign rem_i  = rem0;
			assign nlo_i  = nlo0;
			assign q_i    = '{default: '0};
			assign len_i  = len;
			assign side_i = '{neg: side_in.neg, dg: side_in.dg};
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign nlo_i  = nlo_s[k-1];
			assign q_i    = q_s[k-1];
			assign len_i  = len_s[k-1];
			assign side_i = side_s[k-1];
		end

		// shift in the next numerator bit and subtract when it fits
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r[i]     = {rem_i[i], nlo_i[i][J]};
				rem_n[i] = r[i][ROOT_W-1:0];
				q_n[i]   = q_i[i];
				if (r[i] >= {1'b0, len_i}) begin
					rem_n[i]  = ROOT_W'(r[i] - {1'b0, len_i});
					q_n[i][J] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= rem_n;
				nlo_s[k]  <= nlo_i;
				q_s[k]    <= q_n;
				len_s[k]  <= len_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign quo      = q_s[DV_STG-1];
	assign side_out = side_s[DV_STG-1];

endmodule
`default_nettype wire

@@ src/triangle_face_normal_unit.sv @@
// top level of the triangle face normal pipeline
// depends on tfn_pkg, tfn_sqrt and tfn_div
`timescale 1ns / 1ps
`default_nettype none

// Takes one triangle per transaction and returns its unit normal in signed Q2.30.
// The pipeline accepts a triangle in every cycle that in_stall is low and is built from
// seven front stages (edges, cross products, magnitudes, bit length, normalizing
// shift, squares, sum), a 32-stage square root, a 31-stage divider and the output
// register. Each stage moves on when the stage after it is empty or moving, so
// bubbles close up and a stall at the output only holds in_stall once every stage
// is full. A cross product of zero length gives a zero normal with degenerate set.
module triangle_face_normal_unit import tfn_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [COORD_WIDTH-1:0] ax,
	input  wire logic [COORD_WIDTH-1:0] ay,
	input  wire logic [COORD_WIDTH-1:0] az,
	input  wire logic [COORD_WIDTH-1:0] bx,
	input  wire logic [COORD_WIDTH-1:0] by,
	input  wire logic [COORD_WIDTH-1:0] bz,
	input  wire logic [COORD_WIDTH-1:0] cx,
	input  wire logic [COORD_WIDTH-1:0] cy,
	input  wire logic [COORD_WIDTH-1:0] cz,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [OUT_W-1:0]     nx,
	output logic signed [OUT_W-1:0]     ny,
	output logic signed [OUT_W-1:0]     nz,
	output logic                        degenerate
);

	// stage valid bits and advance chain
	logic [NST:1]   v_q;
	logic [NST-1:0] v_up;
	logic [NST+1:1] rdy;

	// valid bit offered to each stage by the one before it
	assign v_up = {v_q[NST-1:1], in_valid};

	always_comb begin
		rdy[NST+1] = ~out_stall;
		for (int k = NST; k >= 1; k--) begin
			rdy[k] = ~v_q[k] | rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NST; k++) begin
				if (rdy[k]) v_q[k] <= v_up[k-1];
			end
		end
	end

	assign in_stall  = ~rdy[1];
	assign out_valid = v_q[NST];

	// stage 1: edge vectors
	logic signed [EDGE_W-1:0] e_s1 [3];
	logic signed [EDGE_W-1:0] f_s1 [3];
	logic [COORD_WIDTH-1:0]   va [3];
	logic [COORD_WIDTH-1:0]   vb [3];
	logic [COORD_WIDTH-1:0]   vc [3];

	assign va = '{ax, ay, az};
	assign vb = '{bx, by, bz};
	assign vc = '{cx, cy, cz};

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int i = 0; i < 3; i++) begin
				e_s1[i] <= $signed({vb[i][COORD_WIDTH-1], vb[i]})
					- $signed({va[i][COORD_WIDTH-1], va[i]});
				f_s1[i] <= $signed({vc[i][COORD_WIDTH-1], vc[i]})
					- $signed({va[i][COORD_WIDTH-1], va[i]});
			end
		end
	end

	// stage 2: the six cross products
	logic signed [PROD_W-1:0] pa_s2 [3];
	logic signed [PROD_W-1:0] pb_s2 [3];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= e_s1[(i + 1) % 3] * f_s1[(i + 2) % 3];
				pb_s2[i] <= f_s1[(i + 1) % 3] * e_s1[(i + 2) % 3];
			end
		end
	end

	// stage 3: cross components split into sign and magnitude
	logic [MAG_W-1:0]           mag_s3 [3];
	logic [2:0]                 neg_s3;
	logic signed [CROSS_W-1:0]  t3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t3[i] = CROSS_W'(pa_s2[i]) - CROSS_W'(pb_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= t3[i][CROSS_W-1];
				mag_s3[i] <= t3[i][CROSS_W-1] ? MAG_W'(-t3[i]) : MAG_W'(t3[i]);
			end
		end
	end

	// stage 4: bit length of the largest magnitude, taken from the or of all three
	logic [MAG_W-1:0] mag_s4 [3];
	logic [2:0]       neg_s4;
	logic [BL_W-1:0]  bl_s4;
	logic [MAG_W-1:0] any4;
	logic [BL_W-1:0]  bl4;

	always_comb begin
		any4 = mag_s3[0] | mag_s3[1] | mag_s3[2];
		bl4  = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (any4[b]) bl4 = BL_W'(b + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			bl_s4  <= bl4;
		end
	end

	// stage 5: shift so the largest magnitude lands in [2^30, 2^31)
	mnorm_t [2:0]     m_s5;
	logic [2:0]       neg_s5;
	logic             dg_s5;
	mnorm_t [2:0]     m5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (bl_s4 > BL_W'(M_W)) begin
				m5[i] = M_W'(mag_s4[i] >> (bl_s4 - BL_W'(M_W)));
			end else begin
				m5[i] = M_W'(mag_s4[i] << (BL_W'(M_W) - bl_s4));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			m_s5   <= m5;
			neg_s5 <= neg_s4;
			dg_s5  <= (bl_s4 == '0);
		end
	end

	// stage 6: squares
	logic [SQ_W-1:0] sq_s6 [3];
	sq_side_t        side_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= SQ_W'(m_s5[i]) * SQ_W'(m_s5[i]);
			end
			side_s6 <= '{m: m_s5, neg: neg_s5, dg: dg_s5};
		end
	end

	// stage 7: sum of squares
	logic [SUM_W-1:0] sum_s7;
	sq_side_t         side_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			sum_s7  <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
			side_s7 <= side_s6;
		end
	end

	// length by square root
	logic [ROOT_W-1:0] root;
	sq_side_t          side_sq;

	tfn_sqrt u_sqrt (
		.clk      (clk),
		.en       (rdy[FRONT_STG+SQ_STG:FRONT_STG+1]),
		.sum      (sum_s7),
		.side_in  (side_s7),
		.root     (root),
		.side_out (side_sq)
	);

	// rounded division of each component by the length
	logic [QUO_W-1:0] quo [3];
	dv_side_t         side_dv;

	tfn_div u_div (
		.clk      (clk),
		.en       (rdy[FRONT_STG+SQ_STG+DV_STG:FRONT_STG+SQ_STG+1]),
		.len      (root),
		.side_in  (side_sq),
		.quo      (quo),
		.side_out (side_dv)
	);

	// output stage: saturate, apply sign, clear on a degenerate triangle
	logic [OUT_W-1:0] n_out [3];
	logic [QUO_W-1:0] sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat[i] = (quo[i] > ONE_Q30) ? ONE_Q30 : quo[i];
			if (side_dv.dg) begin
				n_out[i] = '0;
			end else if (side_dv.neg[i]) begin
				n_out[i] = -OUT_W'(sat[i]);
			end else begin
				n_out[i] = OUT_W'(sat[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST]) begin
			nx         <= n_out[0];
			ny         <= n_out[1];
			nz         <= n_out[2];
			degenerate <= side_dv.dg;
		end
	end

endmodule
`default_nettype wire

@@ test/tb_triangle_face_normal_unit.sv @@
// testbench for the triangle face normal pipeline: directed and random triangles,
// random idling on both channels, results checked against an in-bench predictor
// depends on tfn_pkg and triangle_face_normal_unit
`timescale 1ns / 1ps

module tb_triangle_face_normal_unit;
	import tfn_pkg::*;

	typedef struct {
		logic [COORD_WIDTH-1:0] v [9];
	} triangle_t;

	typedef struct {
		logic [OUT_W-1:0] nx, ny, nz;
		logic             dg;
	} normal_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [COORD_WIDTH-1:0] ax = '0, ay = '0, az = '0;
	logic [COORD_WIDTH-1:0] bx = '0, by = '0, bz = '0;
	logic [COORD_WIDTH-1:0] cx = '0, cy = '0, cz = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [OUT_W-1:0] nx, ny, nz;
	logic                   degenerate;

	triangle_t triangle_q [$];
	normal_t   normal_q [$];
	int        mismatches = 0;
	int        normals_seen = 0;
	bit        holdoff_done = 0;
	int        holdoff_left = 0;

	triangle_face_normal_unit i_dut (
		.clk, .arst_n, .in_valid, .in_stall,
		.ax, .ay, .az, .bx, .by, .bz, .cx, .cy, .cz,
		.out_valid, .out_stall, .nx, .ny, .nz, .degenerate
	);

	always #5 clk = ~clk;

	// unit normal of one triangle, exact fixed-point normalization
	function automatic normal_t unit_normal(triangle_t t);
		logic signed [127:0] se [3], sf [3];
		logic signed [127:0] cr;
		logic [127:0]        mag [3], big;
		bit                  neg [3];
		longint              a;
		longint unsigned     m [3], s, len, bt, res, n;
		int                  bl, sh, j, k;
		normal_t             r;
		for (int i = 0; i < 3; i++) begin
			a = longint'(signed'(t.v[i]));
			se[i] = longint'(signed'(t.v[3+i])) - a;
			sf[i] = longint'(signed'(t.v[6+i])) - a;
		end
		big = '0;
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			cr = se[j] * sf[k] - sf[j] * se[k];
			neg[i] = cr[127];
			mag[i] = neg[i] ? -cr : cr;
			if (mag[i] > big)
				big = mag[i];
		end
		bl = 0;
		for (int b = 0; b < 128; b++)
			if (big[b])
				bl = b + 1;
		r = '{nx: '0, ny: '0, nz: '0, dg: 1'b0};
		if (bl == 0) begin
			r.dg = 1'b1;
			return r;
		end
		// bring the largest magnitude into [2^30, 2^31)
		sh = bl - 31;
		for (int i = 0; i < 3; i++)
			m[i] = (sh >= 0) ? 64'(mag[i] >> sh) : 64'(mag[i] << (-sh));
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		// bitwise integer square root
		res = 0;
		bt = 64'd1 << 62;
		while (bt > s)
			bt >>= 2;
		while (bt != 0) begin
			if (s >= res + bt) begin
				s -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		len = res;
		for (int i = 0; i < 3; i++) begin
			n = ((m[i] << 30) + (len >> 1)) / len;
			if (n > (64'd1 << 30))
				n = 64'd1 << 30;
			if (neg[i])
				n = -n;
			if (i == 0) r.nx = n[31:0];
			else if (i == 1) r.ny = n[31:0];
			else r.nz = n[31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic add_triangle(input logic [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2);
		triangle_t t;
		t.v = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
		triangle_q.push_back(t);
	endtask

	// coordinate with a random magnitude class
	function automatic logic [31:0] rand_coord(input int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
			default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
				: 32'h8000_0000 + $urandom_range(0, 3);
		endcase
	endfunction

	// driver: offers pending triangles with random gaps
	triangle_t cur;
	int        in_gap = 0;
	bit        in_burst = 0;
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				normal_q.push_back(unit_normal(cur));
				nv = 1'b0;
				if ($urandom_range(0, 39) == 0)
					in_burst = !in_burst;
				in_gap = in_burst ? 0 : $urandom_range(0, 19);
			end
			if (!nv) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (triangle_q.size() > 0) begin
					cur = triangle_q.pop_front();
					{ax, ay, az} <= {cur.v[0], cur.v[1], cur.v[2]};
					{bx, by, bz} <= {cur.v[3], cur.v[4], cur.v[5]};
					{cx, cy, cz} <= {cur.v[6], cur.v[7], cur.v[8]};
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	// long hold-off on the receiver so the pipeline fills and stalls its input
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (normals_seen >= 250 && !holdoff_done) begin
			holdoff_done <= 1'b1;
			holdoff_left <= 2000;
		end
	end

	// monitor: checks each normal and draws the receiver's stalls
	int out_wait = 0;
	bit out_burst = 0;
	always @(posedge clk or negedge arst_n) begin
		normal_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				normals_seen++;
				if (normal_q.size() == 0) begin
					report_mismatch("result with no transaction pending");
				end else begin
					e = normal_q.pop_front();
					if (nx !== e.nx)
						report_mismatch($sformatf("nx %h expected %h", nx, e.nx));
					if (ny !== e.ny)
						report_mismatch($sformatf("ny %h expected %h", ny, e.ny));
					if (nz !== e.nz)
						report_mismatch($sformatf("nz %h expected %h", nz, e.nz));
					if (degenerate !== e.dg)
						report_mismatch($sformatf("degenerate %b expected %b",
							degenerate, e.dg));
				end
				if ($urandom_range(0, 39) == 0)
					out_burst = !out_burst;
				out_wait = out_burst ? 0 : $urandom_range(0, 19);
			end else if (out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (out_wait > 0) || (holdoff_left > 0);
		end
	end

	initial begin
		int kind;
		logic [31:0] p [9];
		// directed: degenerate, collinear, unit, extremes, tiny and lopsided triangles
		add_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_triangle(32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000,
			32'h30000, 32'h60000, 32'h90000);
		add_triangle(5, 6, 7, 5, 6, 7, 9, 1, 2);
		add_triangle(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0);
		add_triangle(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0);
		add_triangle(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0);
		add_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
		add_triangle(0, 0, 0, 1, 0, 0, 0, 0, 1);
		add_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		add_triangle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		add_triangle(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		add_triangle(0, 0, 0, 32'h7fff_ffff, 1, 0, 32'h7fff_ffff, 2, 1);
		add_triangle(0, 0, 0, 32'h7fff_ffff, 0, 1, 32'h8000_0000, 1, 0);
		add_triangle(0, 0, 0, 32'h7fff_0000, 0, 0, 0, 32'h7fff_0000, 3);
		add_triangle(1, 1, 1, 2, 2, 2, 1, 1, 2);
		add_triangle(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
			32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff);
		add_triangle(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 0, 32'hffff_ffff, 0);

		// random: mostly well-formed triangles, some degenerate and extreme ones
		repeat (650) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 9; i++)
				p[i] = rand_coord(kind < 3 ? 0 : kind < 6 ? 2 : kind < 8 ? 1 : 3);
			if (kind == 9) begin
				// collinear or repeated vertices
				if ($urandom_range(0, 1))
					for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
				else
					for (int i = 0; i < 3; i++) p[6+i] = p[i];
			end else if (kind == 8) begin
				// small triangle sitting near a far corner
				for (int i = 3; i < 9; i++)
					p[i] = p[i%3] + rand_coord(1);
			end
			add_triangle(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// sample away from the active edge so the driver's updates have settled
		while (triangle_q.size() > 0 || in_valid)
			@(negedge clk);
		while (normal_q.size() > 0)
			@(negedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
